/* rtl/core/cdq_pkg.sv */
// cdq_pkg: shared constants, beat types and ring helpers for the circular deque
// used by cdq_mem, cdq_ctrl and circular_deque_unit; depends on nothing

package cdq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CAP        = DEPTH - 1;

   // widths fixed by the channel fields
   localparam int OP_W     = 3;
   localparam int DOUT_W   = 32;
   localparam int DIN_W    = 32;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 2;
   localparam int FIELD_W  = 4;

   typedef logic [PTR_W-1:0]      ptr_type;
   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_REMOVE     = 3'd4,
      OP_READ       = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_NOSLOT = 2'd3
   } status_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [DIN_W-1:0]  data_in;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [DOUT_W-1:0]   data_out;
      logic [STATUS_W-1:0] status;
      logic [FIELD_W-1:0]  entry_count;
      logic [FIELD_W-1:0]  front_slot;
      logic [FIELD_W-1:0]  back_slot;
   } rsp_type;

   typedef struct packed {
      logic     we;
      ptr_type  waddr;
      word_type wdata;
      ptr_type  raddr;
   } mem_req_type;

   function automatic ptr_type ring_next(input ptr_type p);
      ptr_type r;
      if (p == PTR_W'(DEPTH - 1)) r = '0;
      else r = p + PTR_W'(1);
      return r;
   endfunction

   function automatic ptr_type ring_prev(input ptr_type p);
      ptr_type r;
      if (p == '0) r = PTR_W'(DEPTH - 1);
      else r = p - PTR_W'(1);
      return r;
   endfunction

endpackage

/* rtl/core/cdq_mem.sv */
// cdq_mem: entry storage of the deque, one write and one registered read a cycle
// depends on cdq_pkg

module cdq_mem (
   input  logic                 clock,
   input  cdq_pkg::mem_req_type mem_req,
   output cdq_pkg::word_type    rd_data
);

   cdq_pkg::word_type mem_array [cdq_pkg::DEPTH];
   cdq_pkg::word_type rd_data_ff;

   // read returns the old contents when the same entry is written
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_array[mem_req.raddr];
      if (mem_req.we) begin
         mem_array[mem_req.waddr] <= mem_req.wdata;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/cdq_ctrl.sv */
// cdq_ctrl: deque sequencer; keeps front, back and count, drives the entry memory
// and runs the shift sweep for removal; depends on cdq_pkg

module cdq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cdq_pkg::req_type      req,
   output logic                  res_valid,
   input  logic                  res_ready,
   output cdq_pkg::rsp_type      res,
   output cdq_pkg::mem_req_type  mem_req,
   input  cdq_pkg::word_type     rd_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WAIT,
      S_SHIFT,
      S_RESULT
   } state_type;

   state_type           state_ff;
   cdq_pkg::ptr_type    front_ff;
   cdq_pkg::ptr_type    back_ff;
   cdq_pkg::ptr_type    count_ff;
   cdq_pkg::ptr_type    pos_ff;
   logic                remove_ff;
   cdq_pkg::word_type   data_ff;
   cdq_pkg::status_type status_ff;

   logic                is_full;
   logic                is_empty;
   logic                slot_in_range;
   cdq_pkg::ptr_type    slot_ptr;
   logic [cdq_pkg::PTR_W:0] dist_raw;
   logic [cdq_pkg::PTR_W:0] ring_dist;
   logic                slot_held;
   logic                accept;
   cdq_pkg::word_type   push_word;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_RESULT);
   assign is_full   = (count_ff == cdq_pkg::PTR_W'(cdq_pkg::CAP));
   assign is_empty  = (count_ff == '0);
   assign push_word = cdq_pkg::DATA_WIDTH'(req.data_in);

   // slot is held when its ring distance from the front is below the count
   always_comb begin
      slot_in_range = (32'(req.slot_index) < 32'(cdq_pkg::DEPTH));
      slot_ptr      = cdq_pkg::PTR_W'(req.slot_index);
      dist_raw      = {1'b0, slot_ptr} + (cdq_pkg::PTR_W + 1)'(cdq_pkg::DEPTH)
                      - {1'b0, front_ff};
      if (dist_raw >= (cdq_pkg::PTR_W + 1)'(cdq_pkg::DEPTH)) begin
         ring_dist = dist_raw - (cdq_pkg::PTR_W + 1)'(cdq_pkg::DEPTH);
      end else begin
         ring_dist = dist_raw;
      end
      slot_held = slot_in_range && (ring_dist < {1'b0, count_ff});
   end

   always_comb begin
      mem_req.we    = 1'b0;
      mem_req.waddr = back_ff;
      mem_req.wdata = push_word;
      mem_req.raddr = front_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req.operation)
                  cdq_pkg::OP_PUSH_BACK: begin
                     mem_req.we    = !is_full;
                     mem_req.waddr = back_ff;
                  end
                  cdq_pkg::OP_PUSH_FRONT: begin
                     mem_req.we    = !is_full;
                     mem_req.waddr = cdq_pkg::ring_prev(front_ff);
                  end
                  cdq_pkg::OP_POP_FRONT: mem_req.raddr = front_ff;
                  cdq_pkg::OP_POP_BACK:  mem_req.raddr = cdq_pkg::ring_prev(back_ff);
                  cdq_pkg::OP_REMOVE,
                  cdq_pkg::OP_READ:      mem_req.raddr = slot_ptr;
                  default:               mem_req.raddr = front_ff;
               endcase
            end
         end
         S_WAIT: begin
            mem_req.raddr = cdq_pkg::ring_next(pos_ff);
         end
         S_SHIFT: begin
            // move the fetched successor down, fetch the one after it
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_ff;
            mem_req.wdata = rd_data;
            mem_req.raddr = cdq_pkg::ring_next(cdq_pkg::ring_next(pos_ff));
         end
         default: begin
            mem_req.we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         front_ff  <= '0;
         back_ff   <= '0;
         count_ff  <= '0;
         pos_ff    <= '0;
         remove_ff <= 1'b0;
         status_ff <= cdq_pkg::ST_OK;
         data_ff   <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  data_ff   <= '0;
                  status_ff <= cdq_pkg::ST_OK;
                  remove_ff <= 1'b0;
                  state_ff  <= S_RESULT;
                  case (req.operation)
                     cdq_pkg::OP_PUSH_BACK: begin
                        if (is_full) begin
                           status_ff <= cdq_pkg::ST_FULL;
                        end else begin
                           data_ff  <= push_word;
                           back_ff  <= cdq_pkg::ring_next(back_ff);
                           count_ff <= count_ff + cdq_pkg::PTR_W'(1);
                        end
                     end
                     cdq_pkg::OP_PUSH_FRONT: begin
                        if (is_full) begin
                           status_ff <= cdq_pkg::ST_FULL;
                        end else begin
                           data_ff  <= push_word;
                           front_ff <= cdq_pkg::ring_prev(front_ff);
                           count_ff <= count_ff + cdq_pkg::PTR_W'(1);
                        end
                     end
                     cdq_pkg::OP_POP_FRONT: begin
                        if (is_empty) begin
                           status_ff <= cdq_pkg::ST_EMPTY;
                        end else begin
                           front_ff <= cdq_pkg::ring_next(front_ff);
                           count_ff <= count_ff - cdq_pkg::PTR_W'(1);
                           state_ff <= S_WAIT;
                        end
                     end
                     cdq_pkg::OP_POP_BACK: begin
                        if (is_empty) begin
                           status_ff <= cdq_pkg::ST_EMPTY;
                        end else begin
                           back_ff  <= cdq_pkg::ring_prev(back_ff);
                           count_ff <= count_ff - cdq_pkg::PTR_W'(1);
                           state_ff <= S_WAIT;
                        end
                     end
                     cdq_pkg::OP_REMOVE: begin
                        if (!slot_held) begin
                           status_ff <= cdq_pkg::ST_NOSLOT;
                        end else begin
                           // back_ff becomes the old last entry, where the sweep stops
                           pos_ff    <= slot_ptr;
                           remove_ff <= 1'b1;
                           back_ff   <= cdq_pkg::ring_prev(back_ff);
                           count_ff  <= count_ff - cdq_pkg::PTR_W'(1);
                           state_ff  <= S_WAIT;
                        end
                     end
                     cdq_pkg::OP_READ: begin
                        if (!slot_held) begin
                           status_ff <= cdq_pkg::ST_NOSLOT;
                        end else begin
                           state_ff <= S_WAIT;
                        end
                     end
                     default: begin
                        status_ff <= cdq_pkg::ST_OK;
                     end
                  endcase
               end
            end
            S_WAIT: begin
               data_ff <= rd_data;
               if (remove_ff && (pos_ff != back_ff)) begin
                  state_ff <= S_SHIFT;
               end else begin
                  state_ff <= S_RESULT;
               end
            end
            S_SHIFT: begin
               pos_ff <= cdq_pkg::ring_next(pos_ff);
               if (cdq_pkg::ring_next(pos_ff) == back_ff) begin
                  state_ff <= S_RESULT;
               end
            end
            S_RESULT: begin
               if (res_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      res.data_out    = cdq_pkg::DOUT_W'(data_ff);
      res.status      = status_ff;
      res.entry_count = cdq_pkg::FIELD_W'(count_ff);
      res.front_slot  = cdq_pkg::FIELD_W'(front_ff);
      res.back_slot   = cdq_pkg::FIELD_W'(cdq_pkg::ring_prev(back_ff));
   end

endmodule

/* rtl/core/circular_deque_unit.sv */
// circular_deque_unit: top level of the circular deque with its result register
// depends on cdq_pkg, cdq_mem and cdq_ctrl
//
// Usage:
//   req_ channel carries one operation a beat: push back, push front, pop front,
//   pop back, remove at a physical slot, read a physical slot. rsp_ channel returns
//   one beat per operation with the data, status, count and front/back slots.
//   Both channels are valid/ready; a beat moves when valid and ready are high.
//   Entries live in a ring memory with one registered read port; one operation is
//   worked on at a time.
//   Pushes and error cases go from the request beat straight to the result;
//   pops, reads and removes first wait for the registered memory read, and a remove
//   then slides the entries behind the removed one down (one memory write per cycle).
//   A new request is taken the cycle after the previous result enters the output
//   register, so a request is never taken while a result is still pending.
//   The output register lets the block take the next request while a result waits;
//   if rsp_ready stays low the next result is held inside until the register frees.
//   Reset empties the deque (front, back and count to zero); entry contents are not
//   cleared.

module circular_deque_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cdq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cdq_pkg::rsp_type rsp_payload
);

   cdq_pkg::mem_req_type mem_req;
   cdq_pkg::word_type    rd_data;
   cdq_pkg::rsp_type     res;
   logic                 res_valid;
   logic                 res_ready;

   logic                 rsp_valid_ff;
   cdq_pkg::rsp_type     rsp_payload_ff;

   cdq_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req_payload),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_payload_ff <= res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_no_accept_with_pending: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !res_valid)
      else $error("request taken while a result is still pending");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready) |=> rsp_valid)
      else $error("handed-off result did not reach the output register");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_payload.entry_count) <= 32'(cdq_pkg::CAP)))
      else $error("entry count beyond capacity");

   a_full_means_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status == cdq_pkg::ST_FULL))
      |-> (32'(rsp_payload.entry_count) == 32'(cdq_pkg::CAP)))
      else $error("full status with room left");

endmodule
